@@ src/trikg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// trikg_pkg
// Shared types, codes, table builders and helpers of the triplet kernel
// gradient block.
// ---------------------------------------------------------------------------
package trikg_pkg;

	localparam int NUM_POINTS_DEF = 64;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int IDX_W   = 6;
	localparam int KVAL_W  = 32;
	localparam int ACC_W   = 48;
	localparam int CNT_W   = 24;
	localparam int LT_W    = 35;     // Kbb - 2Kab - Kcc + 2Kac never exceeds this
	localparam int TAB_LEN = 513;
	localparam int TAB_MID = 256;
	localparam int TIDX_W  = 10;
	localparam logic [63:0] W_Q32 = 64'd4034748382;   // e^(-1/16) in Q32

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// command codes
	localparam logic [2:0] CMD_LOAD  = 3'd0;
	localparam logic [2:0] CMD_CLEAR = 3'd1;
	localparam logic [2:0] CMD_TRIP  = 3'd2;
	localparam logic [2:0] CMD_RDG   = 3'd3;
	localparam logic [2:0] CMD_RDR   = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]               cmd;
		logic [IDX_W-1:0]         row_index;
		logic [IDX_W-1:0]         col_index;
		logic signed [KVAL_W-1:0] kernel_value;
		logic [IDX_W-1:0]         anchor_point;
		logic [IDX_W-1:0]         near_point;
		logic [IDX_W-1:0]         far_point;
	} item_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] result_value;
		logic [CNT_W-1:0]        triplet_total;
		logic [1:0]              status;
	} result_t;

	typedef enum logic [3:0] {
		S_SWEEP, S_IDLE, S_KRD, S_LT, S_TAB, S_GRD, S_GWR, S_DSTART, S_DIV, S_EMIT
	} state_t;

	typedef logic [31:0] tab_t [TAB_LEN];

	// Elaboration-time unsigned long division, restoring, one bit per pass.
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r    = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Elaboration-time build of the sigmoid or softplus table.
	function automatic tab_t make_table(input int frac, input bit softplus);
		logic [63:0] pw  [TAB_MID+1];
		logic [63:0] s30 [TAB_LEN];
		logic [63:0] acc;
		logic [63:0] p;
		logic [63:0] den;
		logic [63:0] num;
		logic [63:0] v;
		tab_t        t;
		int          sh;
		sh = 30 - frac;
		pw[0] = 64'd1 << 32;
		for (int i = 1; i <= TAB_MID; i++)
			pw[i] = (pw[i-1] * W_Q32 + (64'd1 << 31)) >> 32;
		for (int i = 0; i < TAB_LEN; i++) begin
			p   = (i <= TAB_MID) ? pw[TAB_MID-i] : pw[i-TAB_MID];
			den = (64'd1 << 32) + p;
			num = (i <= TAB_MID) ? (p << 30) : (64'd1 << 62);
			s30[i] = udiv64(num + (den >> 1), den);
		end
		acc = s30[0];
		for (int i = 0; i < TAB_LEN; i++) begin
			if (i > 0)
				acc = acc + ((s30[i-1] + s30[i] + 64'd16) >> 5);
			v = softplus ? acc : s30[i];
			t[i] = 32'((v + (64'd1 << (sh - 1))) >> sh);
		end
		return t;
	endfunction

	function automatic logic [ACC_W-1:0] sat48(input logic signed [ACC_W:0] v);
		if (v[ACC_W] != v[ACC_W-1])
			return v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		return v[ACC_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ src/triplet_kernel_gradient_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// triplet_kernel_gradient_top
// Kernel store, triplet logistic-loss gradient accumulation and mean reads.
// ---------------------------------------------------------------------------
// Usage
//  - cmd channel (cmd_valid / cmd_stall / cmd_data) carries one command per
//    transfer: load kernel entry, clear sums, triplet, read gradient, read risk.
//  - res channel (res_valid / res_stall / res_data) returns exactly one result
//    per command, in order.
//  - One command is worked on at a time. Load and ignored commands go
//    straight to the result; a triplet makes four kernel reads, then six
//    read-modify-writes on the single-port gradient memory; reads run the
//    serial divider, one quotient bit a cycle; clear runs a zeroing sweep
//    of the gradient memory.
//  - After reset the gradient memory is swept to zero with cmd_stall held
//    high; count and risk clear at once.
//  - A finished result sits in the output register; while the receiver
//    stalls it holds, and the next command may still be worked on up to its
//    own result, which then waits.
//  - Kernel entries never loaded read as undefined.
// ---------------------------------------------------------------------------
module triplet_kernel_gradient_top #(
	parameter int NUM_POINTS = trikg_pkg::NUM_POINTS_DEF,
	parameter int FRAC_BITS  = trikg_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire trikg_pkg::item_t   cmd_data,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output trikg_pkg::result_t      res_data
);
	localparam int DEPTH = NUM_POINTS * NUM_POINTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int LTW   = trikg_pkg::LT_W;
	localparam int GW    = trikg_pkg::ACC_W;
	localparam int TW    = trikg_pkg::TIDX_W;

	localparam trikg_pkg::tab_t SIG_TAB = trikg_pkg::make_table(FRAC_BITS, 1'b0);
	localparam trikg_pkg::tab_t SP_TAB  = trikg_pkg::make_table(FRAC_BITS, 1'b1);

	localparam logic signed [LTW-1:0] LT_LIM = LTW'(64'd16 << FRAC_BITS);
	localparam logic [LTW-1:0]        LT_RND = LTW'(64'd1 << (FRAC_BITS - 5));
	localparam logic [TW-1:0]         IDX_TOP = TW'(trikg_pkg::TAB_LEN - 1);

	function automatic logic in_rng(input logic [trikg_pkg::IDX_W-1:0] i);
		return 32'(i) < 32'(NUM_POINTS);
	endfunction

	function automatic logic [AW-1:0] cell_addr(input logic [trikg_pkg::IDX_W-1:0] r,
		input logic [trikg_pkg::IDX_W-1:0] c);
		return AW'(32'(r) * 32'(NUM_POINTS) + 32'(c));
	endfunction

	trikg_pkg::state_t state_q, state_d;
	trikg_pkg::item_t  item_q;
	trikg_pkg::result_t res_q;

	logic                       res_valid_q;
	logic                       res_free;
	logic                       accept;
	logic [2:0]                 step_q;
	logic [AW-1:0]              sweep_q;
	logic                       boot_q;
	logic                       sweep_end;

	// kernel memory
	logic signed [31:0]         kmem [DEPTH];
	logic [AW-1:0]              kaddr;
	logic                       kwe;
	logic signed [31:0]         krd_q;

	// gradient memory
	logic [GW-1:0]              gmem [DEPTH];
	logic [AW-1:0]              gaddr;
	logic                       gwe;
	logic [GW-1:0]              gwd;
	logic [GW-1:0]              grd_q;

	logic signed [LTW-1:0]      lt_q;
	logic signed [LTW-1:0]      kx;
	logic signed [LTW-1:0]      term;
	logic signed [LTW-1:0]      lt_c;
	logic [LTW-1:0]             off;
	logic [LTW-1:0]             idx_raw;
	logic [TW-1:0]              idx_q;
	logic [31:0]                p_q;
	logic [31:0]                sp_q;
	logic signed [GW:0]         pw;
	logic signed [GW:0]         delta;
	logic [GW-1:0]              gnew;
	logic [GW-1:0]              risk_new;
	logic signed [GW-1:0]       risk_q;
	logic [trikg_pkg::CNT_W-1:0] cnt_q;
	logic signed [GW-1:0]       pres_q;
	logic [1:0]                 pst_q;
	logic [1:0]                 st_d;

	logic                       rc_ok;
	logic                       trip_ok;
	logic                       cnt_full;
	logic                       cnt_zero;
	logic                       div_start;
	logic                       div_done;
	logic signed [GW-1:0]       div_quot;
	logic signed [GW-1:0]       div_num;

	assign accept    = cmd_valid && !cmd_stall;
	assign res_free  = !res_valid_q || !res_stall;
	assign sweep_end = sweep_q == AW'(DEPTH - 1);
	assign rc_ok     = in_rng(cmd_data.row_index) && in_rng(cmd_data.col_index);
	assign trip_ok   = in_rng(cmd_data.anchor_point) && in_rng(cmd_data.near_point)
		&& in_rng(cmd_data.far_point);
	assign cnt_full  = cnt_q == trikg_pkg::CNT_MAX;
	assign cnt_zero  = cnt_q == '0;

	// status decided at transfer time
	always_comb begin
		st_d = trikg_pkg::ST_OK;
		if (cmd_data.cmd == trikg_pkg::CMD_TRIP && trip_ok && cnt_full)
			st_d = trikg_pkg::ST_FULL;
		else if ((cmd_data.cmd == trikg_pkg::CMD_RDG || cmd_data.cmd == trikg_pkg::CMD_RDR)
			&& cnt_zero)
			st_d = trikg_pkg::ST_EMPTY;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			trikg_pkg::S_SWEEP: begin
				if (sweep_end)
					state_d = boot_q ? trikg_pkg::S_IDLE : trikg_pkg::S_EMIT;
			end
			trikg_pkg::S_IDLE: begin
				if (accept) begin
					priority if (cmd_data.cmd == trikg_pkg::CMD_CLEAR)
						state_d = trikg_pkg::S_SWEEP;
					else if (cmd_data.cmd == trikg_pkg::CMD_TRIP && trip_ok && !cnt_full)
						state_d = trikg_pkg::S_KRD;
					else if ((cmd_data.cmd == trikg_pkg::CMD_RDG && !cnt_zero && rc_ok)
						|| (cmd_data.cmd == trikg_pkg::CMD_RDR && !cnt_zero))
						state_d = trikg_pkg::S_DSTART;
					else
						state_d = trikg_pkg::S_EMIT;
				end
			end
			trikg_pkg::S_KRD:    if (step_q == 3'd4) state_d = trikg_pkg::S_LT;
			trikg_pkg::S_LT:     state_d = trikg_pkg::S_TAB;
			trikg_pkg::S_TAB:    state_d = trikg_pkg::S_GRD;
			trikg_pkg::S_GRD:    state_d = trikg_pkg::S_GWR;
			trikg_pkg::S_GWR:    state_d = (step_q == 3'd5) ? trikg_pkg::S_EMIT : trikg_pkg::S_GRD;
			trikg_pkg::S_DSTART: state_d = trikg_pkg::S_DIV;
			trikg_pkg::S_DIV:    if (div_done) state_d = trikg_pkg::S_EMIT;
			trikg_pkg::S_EMIT:   if (res_free) state_d = trikg_pkg::S_IDLE;
			default:             state_d = trikg_pkg::S_IDLE;
		endcase
	end

	// kernel term of the current read: +Kbb, -2Kab, -Kcc, +2Kac
	assign kx = {{(LTW-32){krd_q[31]}}, krd_q};
	always_comb begin
		unique case (step_q)
			3'd1:    term = kx;
			3'd2:    term = -(kx <<< 1);
			3'd3:    term = -kx;
			3'd4:    term = kx <<< 1;
			default: term = '0;
		endcase
	end

	// clamp to +-16 and round to a 1/16 table step
	always_comb begin
		if (lt_q > LT_LIM)
			lt_c = LT_LIM;
		else if (lt_q < -LT_LIM)
			lt_c = -LT_LIM;
		else
			lt_c = lt_q;
		off     = lt_c + LT_LIM;
		idx_raw = (off + LT_RND) >> (FRAC_BITS - 4);
	end

	// gradient update value: bb +p, cc -p, ab -2p, ba -2p, ac +2p, ca +2p
	assign pw = {{(GW+1-32){1'b0}}, p_q};
	always_comb begin
		unique case (step_q)
			3'd0:        delta = pw;
			3'd1:        delta = -pw;
			3'd2, 3'd3:  delta = -(pw <<< 1);
			default:     delta = pw <<< 1;
		endcase
	end
	assign gnew     = trikg_pkg::sat48(signed'({grd_q[GW-1], grd_q}) + delta);
	assign risk_new = trikg_pkg::sat48({risk_q[GW-1], risk_q}
		+ signed'({{(GW+1-32){1'b0}}, sp_q}));

	// outputs of the sequencer
	always_comb begin
		cmd_stall = state_q != trikg_pkg::S_IDLE;
		div_start = state_q == trikg_pkg::S_DSTART;
		kwe       = 1'b0;
		kaddr     = cell_addr(cmd_data.row_index, cmd_data.col_index);
		gwe       = 1'b0;
		gwd       = gnew;
		gaddr     = cell_addr(cmd_data.row_index, cmd_data.col_index);
		unique case (state_q)
			trikg_pkg::S_SWEEP: begin
				gwe   = 1'b1;
				gwd   = '0;
				gaddr = sweep_q;
			end
			trikg_pkg::S_IDLE: begin
				kwe = accept && cmd_data.cmd == trikg_pkg::CMD_LOAD && rc_ok;
			end
			trikg_pkg::S_KRD: begin
				unique case (step_q)
					3'd0:    kaddr = cell_addr(item_q.near_point, item_q.near_point);
					3'd1:    kaddr = cell_addr(item_q.anchor_point, item_q.near_point);
					3'd2:    kaddr = cell_addr(item_q.far_point, item_q.far_point);
					default: kaddr = cell_addr(item_q.anchor_point, item_q.far_point);
				endcase
			end
			trikg_pkg::S_GRD, trikg_pkg::S_GWR: begin
				gwe = state_q == trikg_pkg::S_GWR;
				unique case (step_q)
					3'd0:    gaddr = cell_addr(item_q.near_point, item_q.near_point);
					3'd1:    gaddr = cell_addr(item_q.far_point, item_q.far_point);
					3'd2:    gaddr = cell_addr(item_q.anchor_point, item_q.near_point);
					3'd3:    gaddr = cell_addr(item_q.near_point, item_q.anchor_point);
					3'd4:    gaddr = cell_addr(item_q.anchor_point, item_q.far_point);
					default: gaddr = cell_addr(item_q.far_point, item_q.anchor_point);
				endcase
			end
			default: begin
			end
		endcase
	end

	// memories, single port, registered read
	always_ff @(posedge clk) begin
		if (kwe)
			kmem[kaddr] <= cmd_data.kernel_value;
		else
			krd_q <= kmem[kaddr];
	end

	always_ff @(posedge clk) begin
		if (gwe)
			gmem[gaddr] <= gwd;
		else
			grd_q <= gmem[gaddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= trikg_pkg::S_SWEEP;
			boot_q      <= 1'b1;
			sweep_q     <= '0;
			step_q      <= '0;
			cnt_q       <= '0;
			risk_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == trikg_pkg::S_SWEEP) begin
				sweep_q <= sweep_end ? '0 : sweep_q + 1'b1;
				if (sweep_end)
					boot_q <= 1'b0;
			end
			if (state_q == trikg_pkg::S_IDLE || state_q == trikg_pkg::S_TAB)
				step_q <= '0;
			else if (state_q == trikg_pkg::S_KRD || state_q == trikg_pkg::S_GWR)
				step_q <= step_q + 1'b1;
			if (accept && cmd_data.cmd == trikg_pkg::CMD_CLEAR) begin
				cnt_q  <= '0;
				risk_q <= '0;
			end
			if (state_q == trikg_pkg::S_GWR && step_q == 3'd5) begin
				risk_q <= risk_new;
				cnt_q  <= cnt_q + 1'b1;
			end
			if (state_q == trikg_pkg::S_EMIT && res_free)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= cmd_data;
			pres_q <= '0;
			pst_q  <= st_d;
			lt_q   <= '0;
		end
		if (state_q == trikg_pkg::S_KRD)
			lt_q <= lt_q + term;
		if (state_q == trikg_pkg::S_LT)
			idx_q <= (idx_raw > LTW'(IDX_TOP)) ? IDX_TOP : idx_raw[TW-1:0];
		if (state_q == trikg_pkg::S_TAB) begin
			p_q  <= SIG_TAB[idx_q];
			sp_q <= SP_TAB[idx_q];
		end
		if (state_q == trikg_pkg::S_DIV && div_done)
			pres_q <= div_quot;
		if (state_q == trikg_pkg::S_EMIT && res_free) begin
			res_q.result_value  <= pres_q;
			res_q.triplet_total <= cnt_q;
			res_q.status        <= pst_q;
		end
	end

	assign div_num = (item_q.cmd == trikg_pkg::CMD_RDR) ? risk_q : signed'(grd_q);

	trikg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule
`default_nettype wire

@@ src/trikg_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// trikg_div
// Serial signed-by-unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ---------------------------------------------------------------------------
module trikg_div (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic signed [trikg_pkg::ACC_W-1:0]   dividend,
	input  wire logic [trikg_pkg::CNT_W-1:0]          divisor,
	output logic                                      done,
	output logic signed [trikg_pkg::ACC_W-1:0]        quotient
);
	localparam int AW = trikg_pkg::ACC_W;
	localparam int CW = trikg_pkg::CNT_W;

	logic [AW-1:0]      q_q;
	logic [CW-1:0]      rem_q;
	logic [CW-1:0]      div_q;
	logic [$clog2(AW)-1:0] cnt_q;
	logic               neg_q;
	logic               busy_q;
	logic               done_q;
	logic [CW:0]        trial;
	logic               fits;

	assign trial = {rem_q, q_q[AW-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(AW))'(AW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend[AW-1] ? (~dividend + 1'b1) : dividend;
			neg_q <= dividend[AW-1];
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			q_q   <= {q_q[AW-2:0], fits};
			rem_q <= fits ? CW'(trial - {1'b0, div_q}) : trial[CW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -signed'(q_q) : signed'(q_q);

endmodule
`default_nettype wire

@@ src/trikg_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// trikg_chk
// Port-level checks of the triplet kernel gradient block, bound to the top.
// ---------------------------------------------------------------------------
module trikg_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               cmd_valid,
	input wire logic               cmd_stall,
	input wire logic               res_valid,
	input wire logic               res_stall,
	input wire trikg_pkg::result_t res_data
);

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("result changed under stall");

	// one command in flight: stall rises right after a transfer
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("second command taken before result");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.status == trikg_pkg::ST_EMPTY
		|-> res_data.result_value == '0 && res_data.triplet_total == '0)
		else $error("empty status with nonzero fields");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.status == trikg_pkg::ST_FULL
		|-> res_data.triplet_total == trikg_pkg::CNT_MAX && res_data.result_value == '0)
		else $error("full status with count below limit");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.status != 2'd3)
		else $error("undefined status");

endmodule

bind triplet_kernel_gradient_top trikg_chk u_trikg_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);
`default_nettype wire
